FILE: design/brts_pkg.sv
`default_nettype none

package brts_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned HSAT_W  = 31;
    localparam int unsigned DIFF_W  = 35;
    localparam int unsigned CHUNK_W = 17;
    localparam int unsigned PROD_W  = DIFF_W + CHUNK_W;
    localparam int unsigned TERM_W  = 68;
    localparam int unsigned RES_W   = 44;
    localparam int unsigned SUM_W   = 48;

    localparam logic [DATA_W-1:0] EFF_Q32  = 32'd3435973837;
    localparam logic [DATA_W-1:0] KD_Q32   = 32'd42950;
    localparam logic [DATA_W-1:0] KA_Q32   = 32'd85899;
    localparam logic [DATA_W-1:0] KDET_Q32 = 32'd21475;

    localparam logic [DATA_W-1:0] RND_MULQ = 32'h8000_0000;
    localparam logic [DATA_W-1:0] RND_CONS = 32'h0040_0000;
    localparam logic [DATA_W-1:0] RND_GROW = 32'h0080_0000;
    localparam int unsigned SH_MULQ = 32;
    localparam int unsigned SH_CONS = 23;
    localparam int unsigned SH_GROW = 24;

    typedef enum logic [3:0] {
        OP_SDIF,
        OP_SADV,
        OP_PDIF,
        OP_PADV,
        OP_PKD,
        OP_PKA,
        OP_PKDT,
        OP_AKA,
        OP_AKD,
        OP_AKDT,
        OP_MIX,
        OP_RDT,
        OP_CONS,
        OP_GROW
    } op_t;

    typedef struct packed {
        logic                     valid;
        logic                     hi;
        op_t                      op;
        logic signed [DIFF_W-1:0] v;
        logic [DATA_W-1:0]        g;
        logic                     g_signed;
    } mac_issue_t;

    typedef struct packed {
        logic                    busy;
        logic                    valid;
        op_t                     op;
        logic signed [RES_W-1:0] value;
    } mac_out_t;

    typedef struct packed {
        logic                     done;
        logic                     fault;
        logic signed [DATA_W-1:0] ratio;
    } div_out_t;

endpackage

`default_nettype wire

FILE: design/biofilm_reaction_transport_stencil.sv
// First and lone edge cells pass via the result registers into the free output register.
// An interior cell's result waits on the 33-step Monod divider, followed by the dependent
// growth-rate, consumption and growth multiplies. The block takes no new word until the
// previous cell is done, and when the final cell also sends its copy, both go out first; it
// takes the next word while a result waits in the output register. Reset (synchronous,
// aresetn low) clears the row position, the sequencer, the output valid and restores the
// register defaults.
`default_nettype none

module biofilm_reaction_transport_stencil
    import brts_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [4:0]               paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_substrate,
    input  wire logic signed [DATA_W-1:0] s_planktonic,
    input  wire logic signed [DATA_W-1:0] s_adhered,
    input  wire logic                     s_last_cell,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_new_substrate,
    output logic signed [DATA_W-1:0]      m_new_planktonic,
    output logic signed [DATA_W-1:0]      m_new_adhered,
    output logic                          m_row_end,
    output logic                          m_clipped
);

    localparam logic [2:0] REG_ADVECT = 3'd0;
    localparam logic [2:0] REG_SDIFF  = 3'd1;
    localparam logic [2:0] REG_BDIFF  = 3'd2;
    localparam logic [2:0] REG_GROWTH = 3'd3;
    localparam logic [2:0] REG_HSAT   = 3'd4;

    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_SAT, ST_PUT} state_t;

    function automatic logic [DATA_W:0] sat32(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-DATA_W:0] top_bits;
        top_bits = x[SUM_W-1:DATA_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            return {1'b0, x[DATA_W-1:0]};
        end else if (x[SUM_W-1]) begin
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic [DATA_W-1:0] advect_gain_reg;
    logic [DATA_W-1:0] substrate_diff_gain_reg;
    logic [DATA_W-1:0] biomass_diff_gain_reg;
    logic [DATA_W-1:0] growth_gain_reg;
    logic [HSAT_W-1:0] half_saturation_reg;

    state_t                   state_reg;
    logic [1:0]               cells_seen_reg;
    logic signed [DATA_W-1:0] w0_s_reg, w0_p_reg, w0_a_reg;
    logic signed [DATA_W-1:0] w1_s_reg, w1_p_reg, w1_a_reg;
    logic signed [DATA_W-1:0] c_s_reg, c_p_reg, c_a_reg;
    logic signed [DIFF_W-1:0] dss_reg, dsa_reg, dps_reg, dpa_reg;
    logic signed [SUM_W-1:0]  sum_s_reg, sum_p_reg, sum_a_reg;
    logic signed [DATA_W-1:0] mix_reg;
    logic signed [DATA_W-1:0] rdt_reg;
    logic                     rdt_ok_reg;
    logic                     clip_reg;
    op_t                      op_reg;
    logic                     hi_reg;
    logic                     dup_reg;
    logic [DATA_W-1:0]        res_s_reg, res_p_reg, res_a_reg;
    logic                     res_end_reg;
    logic                     res_clip_reg;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        out_s_reg, out_p_reg, out_a_reg;
    logic                     out_end_reg;
    logic                     out_clip_reg;

    logic                    s_fire;
    logic                    div_start;
    logic                    issue_hold;
    logic                    out_free;
    logic signed [SUM_W-1:0] r_ext;
    logic signed [SUM_W-1:0] mix_sum;
    logic [DATA_W:0]         mix_sat;
    logic [DATA_W:0]         sat_s, sat_p, sat_a;
    mac_issue_t              iss;
    mac_out_t                mac_res;
    div_out_t                div_res;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            advect_gain_reg         <= '0;
            substrate_diff_gain_reg <= '0;
            biomass_diff_gain_reg   <= '0;
            growth_gain_reg         <= 32'd429497;
            half_saturation_reg     <= 31'd8388608;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_ADVECT: advect_gain_reg         <= pwdata;
                REG_SDIFF:  substrate_diff_gain_reg <= pwdata;
                REG_BDIFF:  biomass_diff_gain_reg   <= pwdata;
                REG_GROWTH: growth_gain_reg         <= pwdata;
                REG_HSAT:   half_saturation_reg     <= pwdata[HSAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ADVECT: prdata = advect_gain_reg;
            REG_SDIFF:  prdata = substrate_diff_gain_reg;
            REG_BDIFF:  prdata = biomass_diff_gain_reg;
            REG_GROWTH: prdata = growth_gain_reg;
            REG_HSAT:   prdata = {1'b0, half_saturation_reg};
            default:    prdata = '0;
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign div_start = s_fire && (cells_seen_reg == 2'd2);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        issue_hold = !hi_reg && ((op_reg == OP_RDT && !div_res.done)
                                 || (op_reg == OP_CONS && !rdt_ok_reg));
        iss          = '0;
        iss.valid    = (state_reg == ST_RUN) && !issue_hold;
        iss.hi       = hi_reg;
        iss.op       = op_reg;
        case (op_reg)
            OP_SDIF: begin
                iss.v = dss_reg;
                iss.g = substrate_diff_gain_reg;
            end
            OP_SADV: begin
                iss.v = dsa_reg;
                iss.g = advect_gain_reg;
            end
            OP_PDIF: begin
                iss.v = dps_reg;
                iss.g = biomass_diff_gain_reg;
            end
            OP_PADV: begin
                iss.v = dpa_reg;
                iss.g = advect_gain_reg;
            end
            OP_PKD: begin
                iss.v = DIFF_W'(c_p_reg);
                iss.g = KD_Q32;
            end
            OP_PKA, OP_AKA: begin
                iss.v = DIFF_W'(c_p_reg);
                iss.g = KA_Q32;
            end
            OP_PKDT, OP_AKDT: begin
                iss.v = DIFF_W'(c_a_reg);
                iss.g = KDET_Q32;
            end
            OP_AKD: begin
                iss.v = DIFF_W'(c_a_reg);
                iss.g = KD_Q32;
            end
            OP_MIX: begin
                iss.v = DIFF_W'(c_a_reg);
                iss.g = EFF_Q32;
            end
            OP_RDT: begin
                iss.v = DIFF_W'($signed(div_res.ratio));
                iss.g = growth_gain_reg;
            end
            OP_CONS: begin
                iss.v        = DIFF_W'(rdt_reg);
                iss.g        = mix_reg;
                iss.g_signed = 1'b1;
            end
            OP_GROW: begin
                iss.v        = DIFF_W'(rdt_reg);
                iss.g        = c_p_reg;
                iss.g_signed = 1'b1;
            end
            default: begin
                iss.v = '0;
                iss.g = '0;
            end
        endcase
    end

    brts_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .iss     (iss),
        .res     (mac_res)
    );

    brts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (w1_s_reg),
        .half_sat (half_saturation_reg),
        .div_out  (div_res)
    );

    always_comb begin
        r_ext   = SUM_W'($signed(mac_res.value));
        mix_sum = SUM_W'(c_p_reg) + r_ext;
        mix_sat = sat32(mix_sum);
        sat_s   = sat32(sum_s_reg);
        sat_p   = sat32(sum_p_reg);
        sat_a   = sat32(sum_a_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cells_seen_reg <= 2'd0;
            m_valid_reg    <= 1'b0;
            rdt_ok_reg     <= 1'b0;
            hi_reg         <= 1'b0;
            dup_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (cells_seen_reg)
                            2'd0: begin
                                res_s_reg      <= s_substrate;
                                res_p_reg      <= s_planktonic;
                                res_a_reg      <= s_adhered;
                                res_end_reg    <= s_last_cell;
                                res_clip_reg   <= 1'b0;
                                dup_reg        <= 1'b0;
                                w0_s_reg       <= w1_s_reg;
                                w0_p_reg       <= w1_p_reg;
                                w0_a_reg       <= w1_a_reg;
                                w1_s_reg       <= s_substrate;
                                w1_p_reg       <= s_planktonic;
                                w1_a_reg       <= s_adhered;
                                cells_seen_reg <= s_last_cell ? 2'd0 : 2'd1;
                                state_reg      <= ST_PUT;
                            end
                            2'd1: begin
                                if (s_last_cell) begin
                                    res_s_reg      <= w1_s_reg;
                                    res_p_reg      <= w1_p_reg;
                                    res_a_reg      <= w1_a_reg;
                                    res_end_reg    <= 1'b1;
                                    res_clip_reg   <= 1'b0;
                                    dup_reg        <= 1'b0;
                                    cells_seen_reg <= 2'd0;
                                    state_reg      <= ST_PUT;
                                end else begin
                                    w0_s_reg       <= w1_s_reg;
                                    w0_p_reg       <= w1_p_reg;
                                    w0_a_reg       <= w1_a_reg;
                                    w1_s_reg       <= s_substrate;
                                    w1_p_reg       <= s_planktonic;
                                    w1_a_reg       <= s_adhered;
                                    cells_seen_reg <= 2'd2;
                                end
                            end
                            default: begin
                                c_s_reg     <= w1_s_reg;
                                c_p_reg     <= w1_p_reg;
                                c_a_reg     <= w1_a_reg;
                                dss_reg     <= DIFF_W'(s_substrate) - (DIFF_W'(w1_s_reg) <<< 1)
                                               + DIFF_W'(w0_s_reg);
                                dsa_reg     <= DIFF_W'(w1_s_reg) - DIFF_W'(w0_s_reg);
                                dps_reg     <= DIFF_W'(s_planktonic) - (DIFF_W'(w1_p_reg) <<< 1)
                                               + DIFF_W'(w0_p_reg);
                                dpa_reg     <= DIFF_W'(w1_p_reg) - DIFF_W'(w0_p_reg);
                                sum_s_reg   <= SUM_W'(w1_s_reg);
                                sum_p_reg   <= SUM_W'(w1_p_reg);
                                sum_a_reg   <= SUM_W'(w1_a_reg);
                                clip_reg    <= 1'b0;
                                rdt_ok_reg  <= 1'b0;
                                op_reg      <= OP_SDIF;
                                hi_reg      <= 1'b0;
                                dup_reg     <= s_last_cell;
                                res_end_reg <= 1'b0;
                                if (s_last_cell) begin
                                    cells_seen_reg <= 2'd0;
                                end else begin
                                    w0_s_reg <= w1_s_reg;
                                    w0_p_reg <= w1_p_reg;
                                    w0_a_reg <= w1_a_reg;
                                    w1_s_reg <= s_substrate;
                                    w1_p_reg <= s_planktonic;
                                    w1_a_reg <= s_adhered;
                                end
                                state_reg <= ST_RUN;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (iss.valid) begin
                        if (hi_reg) begin
                            hi_reg <= 1'b0;
                            if (op_reg == OP_GROW) begin
                                state_reg <= ST_DRAIN;
                            end else begin
                                op_reg <= op_t'(op_reg + 4'd1);
                            end
                        end else begin
                            hi_reg <= 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!mac_res.busy) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    res_s_reg    <= sat_s[DATA_W-1:0];
                    res_p_reg    <= sat_p[DATA_W-1:0];
                    res_a_reg    <= sat_a[DATA_W-1:0];
                    res_clip_reg <= clip_reg | div_res.fault | sat_s[DATA_W]
                                    | sat_p[DATA_W] | sat_a[DATA_W];
                    state_reg    <= ST_PUT;
                end
                ST_PUT: begin
                    if (out_free) begin
                        if (dup_reg) begin
                            dup_reg     <= 1'b0;
                            res_end_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (state_reg == ST_PUT && out_free) begin
                m_valid_reg  <= 1'b1;
                out_s_reg    <= res_s_reg;
                out_p_reg    <= res_p_reg;
                out_a_reg    <= res_a_reg;
                out_end_reg  <= res_end_reg;
                out_clip_reg <= res_clip_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (mac_res.valid) begin
                case (mac_res.op)
                    OP_SDIF:          sum_s_reg <= sum_s_reg + r_ext;
                    OP_SADV, OP_CONS: sum_s_reg <= sum_s_reg - r_ext;
                    OP_PDIF, OP_GROW,
                    OP_PKDT:          sum_p_reg <= sum_p_reg + r_ext;
                    OP_PADV, OP_PKD,
                    OP_PKA:           sum_p_reg <= sum_p_reg - r_ext;
                    OP_AKA:           sum_a_reg <= sum_a_reg + r_ext;
                    OP_AKD, OP_AKDT:  sum_a_reg <= sum_a_reg - r_ext;
                    OP_MIX: begin
                        mix_reg  <= mix_sat[DATA_W-1:0];
                        clip_reg <= clip_reg | mix_sat[DATA_W];
                    end
                    OP_RDT: begin
                        rdt_reg    <= mac_res.value[DATA_W-1:0];
                        rdt_ok_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_new_substrate  = out_s_reg;
    assign m_new_planktonic = out_p_reg;
    assign m_new_adhered    = out_a_reg;
    assign m_row_end        = out_end_reg;
    assign m_clipped        = out_clip_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (iss.valid && !iss.hi && iss.op == OP_RDT) |-> div_res.done)
        else $error("growth-rate multiply issued before the Monod ratio was ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_res.busy)
        else $error("multiply pipeline still busy while accepting words");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(div_res.done) |-> (state_reg == ST_RUN))
        else $error("divider finished outside of an interior cell update");

endmodule

`default_nettype wire

FILE: design/brts_div.sv
`default_nettype none

module brts_div
    import brts_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic [HSAT_W-1:0]        half_sat,
    output div_out_t                      div_out
);

    localparam int unsigned ITER_N = DATA_W + 1;
    localparam int unsigned CNT_W  = $clog2(ITER_N);

    typedef enum logic [1:0] {DV_IDLE, DV_ITER, DV_FIN} dv_state_t;

    dv_state_t                state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W:0]          quo_reg;
    logic [DATA_W:0]          bits_reg;
    logic [DATA_W-1:0]        dvsr_reg;
    logic                     neg_reg;
    logic                     done_reg;
    logic                     fault_reg;
    logic signed [DATA_W-1:0] ratio_reg;

    logic signed [DATA_W:0] den;
    logic [DATA_W-1:0]      mag;
    logic                   ovf;
    logic [DATA_W:0]        r2;
    logic [DATA_W:0]        r2_sub;
    logic                   ge;
    logic [DATA_W:0]        quo_neg;

    always_comb begin
        den    = $signed({2'b00, half_sat}) + $signed({num[DATA_W-1], num});
        mag    = num[DATA_W-1] ? (~num + 1'b1) : num;
        ovf    = (mag >> 9) >= den[DATA_W-1:0];
        r2     = {rem_reg, bits_reg[DATA_W]};
        r2_sub = r2 - {1'b0, dvsr_reg};
        ge     = r2 >= {1'b0, dvsr_reg};
        quo_neg = ~quo_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            fault_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        if (den[DATA_W] || den == '0) begin
                            done_reg  <= 1'b1;
                            fault_reg <= 1'b1;
                            ratio_reg <= '0;
                        end else if (ovf) begin
                            done_reg  <= 1'b1;
                            fault_reg <= 1'b1;
                            ratio_reg <= num[DATA_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        end else begin
                            done_reg  <= 1'b0;
                            fault_reg <= 1'b0;
                            rem_reg   <= mag >> 9;
                            bits_reg  <= {mag[8:0], 24'd0};
                            quo_reg   <= '0;
                            dvsr_reg  <= den[DATA_W-1:0];
                            neg_reg   <= num[DATA_W-1];
                            cnt_reg   <= '0;
                            state_reg <= DV_ITER;
                        end
                    end
                end
                DV_ITER: begin
                    rem_reg  <= ge ? r2_sub[DATA_W-1:0] : r2[DATA_W-1:0];
                    quo_reg  <= {quo_reg[DATA_W-1:0], ge};
                    bits_reg <= {bits_reg[DATA_W-1:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ITER_N - 1)) begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    if (neg_reg) begin
                        if (quo_reg > 33'h0_8000_0000) begin
                            fault_reg <= 1'b1;
                            ratio_reg <= 32'sh8000_0000;
                        end else begin
                            ratio_reg <= quo_neg[DATA_W-1:0];
                        end
                    end else begin
                        if (quo_reg > 33'h0_7FFF_FFFF) begin
                            fault_reg <= 1'b1;
                            ratio_reg <= 32'sh7FFF_FFFF;
                        end else begin
                            ratio_reg <= quo_reg[DATA_W-1:0];
                        end
                    end
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign div_out.done  = done_reg;
    assign div_out.fault = fault_reg;
    assign div_out.ratio = ratio_reg;

endmodule

`default_nettype wire

FILE: design/brts_mac.sv
`default_nettype none

module brts_mac
    import brts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  mac_issue_t iss,
    output mac_out_t   res
);

    logic signed [CHUNK_W-1:0] chunk;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      p1_valid_reg;
    logic                      p1_hi_reg;
    op_t                       p1_op_reg;
    logic                      p2_valid_reg;
    op_t                       p2_op_reg;
    logic signed [TERM_W-1:0]  rnd;
    logic signed [TERM_W-1:0]  t_next;
    logic signed [TERM_W-1:0]  t_reg;
    logic signed [TERM_W-1:0]  shifted;

    always_comb begin
        if (iss.hi) begin
            chunk = {iss.g_signed & iss.g[DATA_W-1], iss.g[DATA_W-1:16]};
        end else begin
            chunk = {1'b0, iss.g[15:0]};
        end
        prod_next = $signed(iss.v) * chunk;
    end

    always_comb begin
        case (p1_op_reg)
            OP_CONS: rnd = TERM_W'(RND_CONS);
            OP_GROW: rnd = TERM_W'(RND_GROW);
            default: rnd = TERM_W'(RND_MULQ);
        endcase
        if (p1_hi_reg) begin
            t_next = t_reg + (TERM_W'(prod_reg) <<< 16);
        end else begin
            t_next = TERM_W'(prod_reg) + rnd;
        end
    end

    always_comb begin
        case (p2_op_reg)
            OP_CONS: shifted = t_reg >>> SH_CONS;
            OP_GROW: shifted = t_reg >>> SH_GROW;
            default: shifted = t_reg >>> SH_MULQ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= iss.valid;
            p2_valid_reg <= p1_valid_reg & p1_hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (iss.valid) begin
            prod_reg <= prod_next;
        end
        p1_hi_reg <= iss.hi;
        p1_op_reg <= iss.op;
        p2_op_reg <= p1_op_reg;
        if (p1_valid_reg) begin
            t_reg <= t_next;
        end
    end

    assign res.busy  = p1_valid_reg | p2_valid_reg;
    assign res.valid = p2_valid_reg;
    assign res.op    = p2_op_reg;
    assign res.value = shifted[RES_W-1:0];

endmodule

`default_nettype wire
